/* hw/rtl/uplink_dmrs_qpsk_generator_assert.svh */
// Assertion macros shared by the generator RTL.
// Both sample on clock and are disabled while reset is high.
`ifndef UPLINK_DMRS_QPSK_GENERATOR_ASSERT_SVH
`define UPLINK_DMRS_QPSK_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define UDQG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UDQG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/udqg_pkg.sv */
package udqg_pkg;

   localparam int unsigned WARMUP_STEPS_DEFAULT = 1600;
   localparam int unsigned QUEUE_DEPTH_DEFAULT  = 2;

   localparam int unsigned OUT_WIDTH  = 16;
   localparam int unsigned INIT_WIDTH = 31;
   localparam int unsigned SCID_WIDTH = 16;
   localparam int unsigned RBS_WIDTH  = 7;
   localparam int unsigned SC_WIDTH   = 11;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register index, taken from the word address bit
   localparam logic REG_SCRAMBLING_ID = 1'b0;
   localparam logic REG_NUM_RBS       = 1'b1;

   localparam logic [SCID_WIDTH-1:0] SCRAMBLING_ID_RESET = '0;
   localparam logic [RBS_WIDTH-1:0]  NUM_RBS_RESET       = 7'd10;
   localparam logic [RBS_WIDTH-1:0]  RBS_MIN             = 7'd10;
   localparam logic [RBS_WIDTH-1:0]  RBS_MAX             = 7'd100;
   localparam int unsigned           SUBCARRIERS_PER_RB  = 12;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_NEXT  = 1'b1;

   localparam logic [3:0] SLOT_MAX         = 4'd9;
   localparam logic [3:0] SYMBOL_MAX       = 4'd13;
   localparam int unsigned SYMBOLS_PER_SLOT = 14;
   // c_init = 2^17 * n * (2*id+1) + 2*id mod 2^31: only n*(2*id+1) mod 2^14 survives
   localparam int unsigned PROD_WIDTH = INIT_WIDTH - 17;

   // 0.7071 in Q1.(OUT_WIDTH-1), rounded
   localparam longint unsigned AMP_WIDE =
      (64'd7071 * (64'd1 << (OUT_WIDTH - 1)) + 64'd5000) / 64'd10000;
   localparam logic signed [OUT_WIDTH-1:0] QPSK_POS = OUT_WIDTH'(AMP_WIDE);
   localparam logic signed [OUT_WIDTH-1:0] QPSK_NEG = -QPSK_POS;

   typedef struct packed {
      logic       mode;
      logic [3:0] slot_index;
      logic [3:0] symbol_index;
   } req_type;

   typedef struct packed {
      logic                        status;
      logic [INIT_WIDTH-1:0]       init_value;
      logic signed [OUT_WIDTH-1:0] i_value;
      logic signed [OUT_WIDTH-1:0] q_value;
      logic                        last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_NEXT,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [INIT_WIDTH-1:0] init_value;
   } cmd_type;

   typedef enum logic {
      BK_RUN,
      BK_WARM
   } back_state_type;

   typedef struct packed {
      logic [30:0] x1;
      logic [30:0] x2;
   } gold_type;

   function automatic gold_type gold_advance(input gold_type g);
      gold_type r;
      r.x1 = {g.x1[0] ^ g.x1[3], g.x1[30:1]};
      r.x2 = {g.x2[0] ^ g.x2[1] ^ g.x2[2] ^ g.x2[3], g.x2[30:1]};
      return r;
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] qpsk_level(input logic b);
      return b ? QPSK_NEG : QPSK_POS;
   endfunction

endpackage

/* hw/rtl/uplink_dmrs_qpsk_generator.sv */
// A request is registered in the request queue; the back end takes it outside warm-up when
//   the result queue has room and registers its result there, where rsp_data shows it.
// Throughput: one next transaction per cycle under those conditions; the generator advances
//   two steps per next transaction. A start holds the back end in warm-up, which runs the
//   Gold generator WARMUP_STEPS steps (1600 by default), one step per cycle.
// Reset (synchronous, active high) empties both queues, zeroes both generator registers
//   and the subcarrier counter, and sets scrambling_id to 0 and num_rbs to 10.
module uplink_dmrs_qpsk_generator #(
   parameter int unsigned WARMUP_STEPS = udqg_pkg::WARMUP_STEPS_DEFAULT,
   parameter int unsigned QUEUE_DEPTH  = udqg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request queue side
   input  logic                                   req_push,
   input  udqg_pkg::req_type                      req_data,
   output logic                                   req_full,
   // result queue side
   output logic                                   rsp_empty,
   output udqg_pkg::rsp_type                      rsp_data,
   input  logic                                   rsp_pop,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [udqg_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [udqg_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [udqg_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   import udqg_pkg::*;

   logic [SCID_WIDTH-1:0] scrambling_id_ff, scrambling_id_in;
   logic [RBS_WIDTH-1:0]  num_rbs_ff, num_rbs_in;
   logic                  csr_write;
   logic                  reg_sel;

   cmd_type               cmd_data;
   logic                  cmd_empty;
   logic                  cmd_pop;
   rsp_type               out_data;
   logic                  out_push;
   logic                  out_full;

   // Register file: word address bit 2 picks the register, byte lanes ignored.
   // Writes complete in the access phase; the port never inserts wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      scrambling_id_in = scrambling_id_ff;
      num_rbs_in       = num_rbs_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_SCRAMBLING_ID: scrambling_id_in = csr_pwdata[SCID_WIDTH-1:0];
            REG_NUM_RBS:       num_rbs_in       = csr_pwdata[RBS_WIDTH-1:0];
            default:           scrambling_id_in = scrambling_id_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SCRAMBLING_ID: csr_prdata = {{(CSR_DATA_WIDTH-SCID_WIDTH){1'b0}}, scrambling_id_ff};
         REG_NUM_RBS:       csr_prdata = {{(CSR_DATA_WIDTH-RBS_WIDTH){1'b0}}, num_rbs_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scrambling_id_ff <= SCRAMBLING_ID_RESET;
         num_rbs_ff       <= NUM_RBS_RESET;
      end else begin
         scrambling_id_ff <= scrambling_id_in;
         num_rbs_ff       <= num_rbs_in;
      end
   end

   // Front end: range-check starts, form c_init, queue the classified command
   udqg_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .req_full      (req_full),
      .scrambling_id (scrambling_id_ff),
      .cmd_pop       (cmd_pop),
      .cmd_data      (cmd_data),
      .cmd_empty     (cmd_empty)
   );

   // Back end: Gold generator, warm-up sequencer, QPSK mapping, subcarrier count
   udqg_back #(
      .WARMUP_STEPS (WARMUP_STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .num_rbs   (num_rbs_ff),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // Result queue: hold finished results until the consumer pops them
   udqg_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .data_type (rsp_type)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

/* hw/rtl/udqg_fifo.sv */
`include "uplink_dmrs_qpsk_generator_assert.svh"

module udqg_fifo #(
   parameter int unsigned DEPTH = udqg_pkg::QUEUE_DEPTH_DEFAULT,
   parameter type data_type = logic [0:0]
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type wr_data,
   output logic     full,
   input  logic     pop,
   output data_type rd_data,
   output logic     empty
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);

   data_type              mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == CntWidth'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `UDQG_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CntWidth'(DEPTH), "fifo count above depth")
   `UDQG_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "fifo count did not rise")
   `UDQG_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1, "fifo count did not fall")

endmodule

/* hw/rtl/udqg_front.sv */
module udqg_front #(
   parameter int unsigned QUEUE_DEPTH = udqg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  udqg_pkg::req_type                     req_data,
   output logic                                  req_full,
   input  logic [udqg_pkg::SCID_WIDTH-1:0]       scrambling_id,
   input  logic                                  cmd_pop,
   output udqg_pkg::cmd_type                     cmd_data,
   output logic                                  cmd_empty
);

   import udqg_pkg::*;

   logic [7:0]            seq_n;
   logic [21:0]           prod_full;
   cmd_type               cmd_in;

   // n = 14*slot + symbol + 1, at most 140 for an in-range start
   assign seq_n = 8'(SYMBOLS_PER_SLOT) * {4'b0, req_data.slot_index}
                  + {4'b0, req_data.symbol_index} + 8'd1;
   // keep only the low bits of (2*id+1) that reach the residue
   assign prod_full = {14'b0, seq_n} * {8'b0, scrambling_id[PROD_WIDTH-2:0], 1'b1};

   always_comb begin
      cmd_in.init_value = {prod_full[PROD_WIDTH-1:0], scrambling_id, 1'b0};
      case (req_data.mode)
         MODE_START: begin
            if (req_data.slot_index > SLOT_MAX || req_data.symbol_index > SYMBOL_MAX) begin
               cmd_in.kind = CMD_REJECT;
            end else begin
               cmd_in.kind = CMD_START;
            end
         end
         MODE_NEXT: cmd_in.kind = CMD_NEXT;
         default:   cmd_in.kind = CMD_NEXT;
      endcase
   end

   udqg_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .data_type (cmd_type)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_in),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd_data),
      .empty   (cmd_empty)
   );

endmodule

/* hw/rtl/udqg_back.sv */
`include "uplink_dmrs_qpsk_generator_assert.svh"

module udqg_back #(
   parameter int unsigned WARMUP_STEPS = udqg_pkg::WARMUP_STEPS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_empty,
   input  udqg_pkg::cmd_type                cmd_data,
   output logic                             cmd_pop,
   input  logic [udqg_pkg::RBS_WIDTH-1:0]   num_rbs,
   input  logic                             out_full,
   output logic                             out_push,
   output udqg_pkg::rsp_type                out_data
);

   import udqg_pkg::*;

   localparam int unsigned WarmWidth = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;
   localparam logic        NoWarmup  = (WARMUP_STEPS == 0);

   back_state_type          state_ff, state_in;
   gold_type                gold_ff, gold_in;
   gold_type                gold_mid, gold_two;
   logic [SC_WIDTH-1:0]     count_ff, count_in;
   logic [WarmWidth-1:0]    warm_ff, warm_in;
   logic                    cmd_go;
   logic                    bit0, bit1;
   logic [RBS_WIDTH-1:0]    rbs_sat;
   logic [SC_WIDTH-1:0]     last_idx;
   logic                    at_last;

   assign cmd_go   = (state_ff == BK_RUN) && !cmd_empty && !out_full;
   assign gold_mid = gold_advance(gold_ff);
   assign gold_two = gold_advance(gold_mid);
   assign bit0     = gold_ff.x1[0] ^ gold_ff.x2[0];
   assign bit1     = gold_mid.x1[0] ^ gold_mid.x2[0];

   assign rbs_sat  = (num_rbs < RBS_MIN) ? RBS_MIN : ((num_rbs > RBS_MAX) ? RBS_MAX : num_rbs);
   assign last_idx = SC_WIDTH'(SUBCARRIERS_PER_RB) * {{(SC_WIDTH-RBS_WIDTH){1'b0}}, rbs_sat}
                     - 1'b1;
   assign at_last  = (count_ff == last_idx);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_RUN: begin
            if (cmd_go && cmd_data.kind == CMD_START && !NoWarmup) begin
               state_in = BK_WARM;
            end
         end
         BK_WARM: begin
            if (warm_ff == WarmWidth'(1)) begin
               state_in = BK_RUN;
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   // Outputs
   always_comb begin
      cmd_pop  = cmd_go;
      out_push = cmd_go;
      out_data = '0;
      case (cmd_data.kind)
         CMD_START:  out_data.init_value = cmd_data.init_value;
         CMD_REJECT: out_data.status     = 1'b1;
         CMD_NEXT: begin
            out_data.i_value = qpsk_level(bit0);
            out_data.q_value = qpsk_level(bit1);
            out_data.last    = at_last;
         end
         default: out_data = '0;
      endcase
   end

   // Generator, subcarrier counter and warm-up counter
   always_comb begin
      gold_in  = gold_ff;
      count_in = count_ff;
      warm_in  = warm_ff;
      if (state_ff == BK_WARM) begin
         gold_in = gold_mid;
         warm_in = warm_ff - 1'b1;
      end else if (cmd_go) begin
         case (cmd_data.kind)
            CMD_START: begin
               gold_in.x1 = 31'd1;
               gold_in.x2 = cmd_data.init_value;
               count_in   = '0;
               warm_in    = WarmWidth'(WARMUP_STEPS);
            end
            CMD_NEXT: begin
               gold_in  = gold_two;
               count_in = at_last ? '0 : count_ff + 1'b1;
            end
            default: gold_in = gold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_RUN;
         gold_ff  <= '0;
         count_ff <= '0;
         warm_ff  <= '0;
      end else begin
         state_ff <= state_in;
         gold_ff  <= gold_in;
         count_ff <= count_in;
         warm_ff  <= warm_in;
      end
   end

   `UDQG_ASSERT_IMPL(a_no_push_in_warmup, state_ff == BK_WARM, !out_push && !cmd_pop, "transaction issued during warm-up")
   `UDQG_ASSERT_NEXT(a_start_enters_warmup, cmd_go && cmd_data.kind == CMD_START, state_ff == BK_WARM || NoWarmup, "start did not enter warm-up")
   `UDQG_ASSERT_NEXT(a_warmup_ends, state_ff == BK_WARM && warm_ff == WarmWidth'(1), state_ff == BK_RUN, "warm-up did not end")
   `UDQG_ASSERT_IMPL(a_push_has_room, out_push, !out_full, "result pushed into full queue")

endmodule

/* verif/tb.sv */
module tb;
   import udqg_pkg::*;

   // Warm-up length the block is built with; the predictor runs the same count.
   localparam int WARMUP_STEPS = 1600;
   // 0.7071 in Q1.(OUT_WIDTH-1), rounded to nearest
   localparam logic signed [OUT_WIDTH-1:0] AMPLITUDE_Q15 =
      OUT_WIDTH'((7071 * (1 << (OUT_WIDTH - 1)) + 5000) / 10000);
   // Longest legal quiet stretch is one warm-up plus a long receiver hold;
   // allow several times that before giving up.
   localparam int QUIET_LIMIT = 4 * (WARMUP_STEPS + 200);
   localparam int RECEIVER_HOLD_CYCLES = 90;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_type;

   // Predicts the DMRS sequence and keeps the results still owed by the block.
   class dmrs_scoreboard;
      rsp_type          pending_results[$];
      logic [30:0]      x1_state = '0;
      logic [30:0]      x2_state = '0;
      logic [10:0]      subcarrier = '0;
      logic [15:0]      scrambling_id = '0;
      logic [6:0]       num_rbs = 7'd10;
      int               errors = 0;
      int               checked = 0;
      int               starts = 0;
      int               rejects = 0;
      int               values = 0;
      int               lasts = 0;

      function void report(input string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void write_register(input logic idx, input logic [31:0] value);
         if (idx == REG_SCRAMBLING_ID) scrambling_id = value[15:0];
         else num_rbs = value[6:0];
      endfunction

      // One Gold step: return c(n), then shift both registers.
      function logic gold_bit();
         logic c;
         c = x1_state[0] ^ x2_state[0];
         x1_state = {x1_state[0] ^ x1_state[3], x1_state[30:1]};
         x2_state = {x2_state[0] ^ x2_state[1] ^ x2_state[2] ^ x2_state[3], x2_state[30:1]};
         return c;
      endfunction

      function logic signed [OUT_WIDTH-1:0] level(input logic b);
         return b ? -AMPLITUDE_Q15 : AMPLITUDE_Q15;
      endfunction

      function void note_request(input req_type req);
         rsp_type           want;
         longint unsigned   n;
         longint unsigned   id;
         longint unsigned   cinit;
         int unsigned       rbs_used;
         logic [10:0]       last_index;
         logic              b0;
         logic              b1;
         want = '0;
         if (req.mode == MODE_START) begin
            if (req.slot_index > SLOT_MAX || req.symbol_index > SYMBOL_MAX) begin
               // rejected: flag only, generator state untouched
               want.status = 1'b1;
               rejects++;
            end else begin
               n = 14 * longint'(req.slot_index) + req.symbol_index + 1;
               id = scrambling_id;
               cinit = ((n * (2 * id + 1)) << 17) + 2 * id;
               want.init_value = cinit[30:0];
               x1_state = 31'd1;
               x2_state = cinit[30:0];
               repeat (WARMUP_STEPS) void'(gold_bit());
               subcarrier = '0;
               starts++;
            end
         end else begin
            rbs_used = num_rbs;
            if (rbs_used < RBS_MIN) rbs_used = RBS_MIN;
            if (rbs_used > RBS_MAX) rbs_used = RBS_MAX;
            last_index = 11'(12 * rbs_used - 1);
            b0 = gold_bit();
            b1 = gold_bit();
            want.i_value = level(b0);
            want.q_value = level(b1);
            if (subcarrier == last_index) begin
               want.last = 1'b1;
               subcarrier = '0;
               lasts++;
            end else begin
               subcarrier = subcarrier + 11'd1;
            end
            values++;
         end
         pending_results.push_back(want);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result: st=%0d init=%h i=%0d q=%0d last=%0d",
                             got.status, got.init_value, got.i_value, got.q_value,
                             got.last));
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.status !== want.status || got.init_value !== want.init_value ||
             got.i_value !== want.i_value || got.q_value !== want.q_value ||
             got.last !== want.last)
            report({$sformatf("result %0d: expected st=%0d init=%h i=%0d q=%0d last=%0d",
                              checked, want.status, want.init_value, want.i_value,
                              want.q_value, want.last),
                    $sformatf(", got st=%0d init=%h i=%0d q=%0d last=%0d",
                              got.status, got.init_value, got.i_value, got.q_value,
                              got.last)});
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   req_type                    req_data = '0;
   logic                       req_full;
   logic                       rsp_empty;
   rsp_type                    rsp_data;
   logic                       rsp_pop = 1'b0;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   dmrs_scoreboard sb = new;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_request = 0;
   int csr_writes = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   uplink_dmrs_qpsk_generator #(.WARMUP_STEPS(WARMUP_STEPS)) dut (
      .clock, .reset,
      .req_push, .req_data, .req_full,
      .rsp_empty, .rsp_data, .rsp_pop,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   function automatic void set_idle(input idle_kind_type kind);
      sender_idle_pct = (kind == IDLE_SENDER) ? 77 : (kind == IDLE_BOTH) ? 30 : 0;
      receiver_stall_pct = (kind == IDLE_RECEIVER) ? 77 : (kind == IDLE_BOTH) ? 30 : 0;
   endfunction

   // Build a request; on a start, valid_only keeps slot and symbol in range.
   function automatic req_type random_request(input logic mode, input bit valid_only);
      req_type r;
      r.mode = mode;
      r.slot_index = valid_only ? 4'($urandom_range(SLOT_MAX)) : 4'($urandom);
      r.symbol_index = valid_only ? 4'($urandom_range(SYMBOL_MAX)) : 4'($urandom);
      return r;
   endfunction

   // Offer one transaction; leave push high so back-to-back items need no extra step.
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         req_data <= random_request(1'($urandom), 1'b0);
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      sb.note_request(item);
   endtask

   task automatic send_fields(input logic mode, input logic [3:0] slot, input logic [3:0] sym);
      req_type r;
      r.mode = mode;
      r.slot_index = slot;
      r.symbol_index = sym;
      send_item(r);
   endtask

   // Drop push and hold until every owed result has been popped.
   task automatic wait_for_drain();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   // Setup then access; leave psel up so a following access needs no idle step.
   task automatic csr_access(input logic idx, input logic write, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Write a register, then read it back and compare the stored bits.
   task automatic csr_write(input logic idx, input logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == REG_SCRAMBLING_ID) ? 32'h0000_FFFF : 32'h0000_007F;
      csr_access(idx, 1'b1, value);
      sb.write_register(idx, value);
      csr_writes++;
      csr_access(idx, 1'b0, '0);
      if (csr_prdata !== (value & mask))
         sb.report($sformatf("register %0d readback: expected %h, got %h",
                             idx, value & mask, csr_prdata));
   endtask

   // Reprogram both registers with the block idle; upper bus bits carry noise.
   task automatic configure(input logic [15:0] scid, input logic [6:0] rbs);
      logic [31:0] noise;
      wait_for_drain();
      noise = $urandom;
      csr_write(REG_SCRAMBLING_ID, {noise[31:16], scid});
      noise = $urandom;
      csr_write(REG_NUM_RBS, {noise[31:7], rbs});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mostly well-formed symbols (valid start plus a run of next transactions),
   // the rest arbitrary starts and stray next transactions.
   task automatic run_phase(input logic [15:0] scid, input logic [6:0] rbs, input int items,
                            input idle_kind_type kind, input bit pressure);
      int sent;
      int run_len;
      int roll;
      bit held;
      bit paused;
      sent = 0;
      held = 0;
      paused = 0;
      configure(scid, rbs);
      set_idle(kind);
      while (sent < items) begin
         if (pressure && !held && sent >= items / 2) begin
            // stall the receiver while the sender keeps offering, so the queues fill
            hold_request = RECEIVER_HOLD_CYCLES;
            held = 1;
         end
         if (pressure && !paused && sent >= 3 * items / 4) begin
            wait_for_drain();
            paused = 1;
         end
         roll = $urandom_range(99);
         if (roll < 80) begin
            send_item(random_request(MODE_START, 1'b1));
            run_len = ($urandom_range(3) == 0) ? $urandom_range(110, 260)
                                               : $urandom_range(1, 40);
            // trim the run so the phase ends on its item budget
            if (run_len > items - sent - 1) run_len = items - sent - 1;
            repeat (run_len) send_item(random_request(MODE_NEXT, 1'b0));
            sent += run_len + 1;
         end else if (roll < 92) begin
            send_item(random_request(MODE_START, 1'b0));
            sent++;
         end else begin
            run_len = $urandom_range(1, 5);
            if (run_len > items - sent) run_len = items - sent;
            repeat (run_len) send_item(random_request(MODE_NEXT, 1'b0));
            sent += run_len;
         end
      end
   endtask

   // Result side: check each popped transaction, then pick the next pop.
   initial begin
      int hold_left;
      bit pop_next;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_data);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop_next = 1'b0;
         end else begin
            pop_next = ($urandom_range(99) >= receiver_stall_pct);
         end
         rsp_pop <= pop_next;
      end
   end

   // Watchdog: end the run if neither side moves a transaction for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, on reset register values.
      set_idle(IDLE_NONE);
      // next before any start: generators are zero, both levels positive
      send_fields(MODE_NEXT, 4'd0, 4'd0);
      send_fields(MODE_NEXT, 4'hF, 4'hF);
      // rejected starts: slot too high, symbol too high, both at the field maximum
      send_fields(MODE_START, 4'd10, 4'd0);
      send_fields(MODE_START, 4'd0, 4'd14);
      send_fields(MODE_START, 4'd15, 4'd15);
      // largest and smallest valid start
      send_fields(MODE_START, SLOT_MAX, SYMBOL_MAX);
      repeat (3) send_item(random_request(MODE_NEXT, 1'b0));
      send_fields(MODE_START, 4'd0, 4'd0);
      repeat (3) send_item(random_request(MODE_NEXT, 1'b0));
      // a rejected start must not disturb the running sequence
      send_fields(MODE_START, 4'd5, 4'd15);
      repeat (2) send_item(random_request(MODE_NEXT, 1'b0));

      // Random part, one register setting and idle profile per phase.
      run_phase(16'd0, RBS_MIN, 110, IDLE_NONE, 1'b0);
      run_phase(16'hFFFF, RBS_MAX, 110, IDLE_SENDER, 1'b0);
      run_phase(16'($urandom), 7'd0, 110, IDLE_RECEIVER, 1'b0);
      run_phase(16'($urandom), 7'($urandom_range(10, 14)), 110, IDLE_BOTH, 1'b0);
      run_phase(16'($urandom), 7'($urandom), 110, IDLE_BOTH, 1'b0);
      run_phase(16'($urandom), RBS_MIN, 150, IDLE_NONE, 1'b1);

      // Shrink the length mid-symbol: the counter runs past the new last subcarrier.
      set_idle(IDLE_NONE);
      configure(16'($urandom), 7'd20);
      send_item(random_request(MODE_START, 1'b1));
      repeat (130) send_item(random_request(MODE_NEXT, 1'b0));
      configure(16'($urandom), RBS_MIN);
      repeat (30) send_item(random_request(MODE_NEXT, 1'b0));

      // Oversized length saturates to the maximum, so no sequence end falls early.
      configure(16'($urandom), 7'd127);
      send_item(random_request(MODE_START, 1'b1));
      repeat (60) send_item(random_request(MODE_NEXT, 1'b0));

      wait_for_drain();
      repeat (20) @(posedge clock);

      $display("Covered %0d accepted and %0d rejected starts, %0d QPSK values, %0d sequence ends",
               sb.starts, sb.rejects, sb.values, sb.lasts);
      $display("  over %0d register writes and four idle profiles, with a full-queue stall",
               csr_writes);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/udqg_pkg.sv
hw/rtl/udqg_fifo.sv
hw/rtl/udqg_front.sv
hw/rtl/udqg_back.sv
hw/rtl/uplink_dmrs_qpsk_generator.sv
verif/tb.sv
